// ----- hw/rtl/bq_pkg.sv -----
package bq_pkg;

  localparam int unsigned SampleWidthDef  = 16;
  localparam int unsigned CoefFracBitsDef = 14;
  localparam int unsigned CoefWidth       = 18;
  localparam int unsigned AddrWidth       = 5;
  localparam int unsigned DataWidth       = 32;

  localparam logic signed [CoefWidth-1:0] CoefB0Reset = 18'sd16384;

  // register index, byte address / 4
  typedef enum logic [AddrWidth-3:0] {
    RegCoefB0 = 3'd0,
    RegCoefB1 = 3'd1,
    RegCoefB2 = 3'd2,
    RegCoefA1 = 3'd3,
    RegCoefA2 = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoefWidth-1:0] b0;
    logic signed [CoefWidth-1:0] b1;
    logic signed [CoefWidth-1:0] b2;
    logic signed [CoefWidth-1:0] a1;
    logic signed [CoefWidth-1:0] a2;
  } coefs_t;

endpackage

// ----- hw/rtl/bq_core.sv -----
module bq_core #(
  parameter int unsigned SAMPLE_WIDTH   = bq_pkg::SampleWidthDef,
  parameter int unsigned COEF_FRAC_BITS = bq_pkg::CoefFracBitsDef
) (
  input  bq_pkg::coefs_t                  coefs_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  x_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  x1_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  x2_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  y1_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  y2_i,
  output logic signed [SAMPLE_WIDTH-1:0]  y_o,
  output logic                            clip_o
);

  localparam int unsigned CW  = bq_pkg::CoefWidth;
  localparam int unsigned PW  = SAMPLE_WIDTH + CW;
  // keep at least one guard bit above the sample after the shift
  localparam int unsigned AW  = (PW + 3 > SAMPLE_WIDTH + COEF_FRAC_BITS + 1) ?
                                (PW + 3) : (SAMPLE_WIDTH + COEF_FRAC_BITS + 1);
  localparam int unsigned RW  = AW - COEF_FRAC_BITS;
  localparam int unsigned XW  = RW - SAMPLE_WIDTH + 1;
  localparam logic signed [AW-1:0] Half = AW'(1) <<< (COEF_FRAC_BITS - 1);

  logic signed [PW-1:0]           p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [AW-1:0]           acc;
  logic signed [AW-1:0]           rnd;
  logic signed [RW-1:0]           res;
  logic        [XW-1:0]           top;

  assign p_b0 = coefs_i.b0 * x_i;
  assign p_b1 = coefs_i.b1 * x1_i;
  assign p_b2 = coefs_i.b2 * x2_i;
  assign p_a1 = coefs_i.a1 * y1_i;
  assign p_a2 = coefs_i.a2 * y2_i;

  assign acc = AW'(p_b0) + AW'(p_b1) + AW'(p_b2) - AW'(p_a1) - AW'(p_a2);
  assign rnd = acc + Half;
  assign res = rnd[AW-1:COEF_FRAC_BITS];
  assign top = res[RW-1:SAMPLE_WIDTH-1];

  always_comb begin
    if (top == '0 || top == '1) begin
      y_o    = res[SAMPLE_WIDTH-1:0];
      clip_o = 1'b0;
    end else if (res[RW-1]) begin
      y_o    = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      clip_o = 1'b1;
    end else begin
      y_o    = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      clip_o = 1'b1;
    end
  end

endmodule

// ----- hw/rtl/biquad_iir_filter_top.sv -----
// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_stall_o    sample_in_i
// output    out        out_valid_o / out_stall_i  sample_out_o, clipped_o
// config    in         APB psel/penable/pwrite    paddr, pwdata, prdata
//
// One sample per cycle while the output is not stalled. A request is held in
// the input register; the five multiplies, the sum, rounding and saturation
// follow and land in the output register together with the history update.
// Reset clears history and valids and loads b0 = 1.0, other coefficients 0.
// A stalled output holds; the input register still takes a request when the
// output register is about to drain.
module biquad_iir_filter_top #(
  parameter int unsigned SAMPLE_WIDTH   = bq_pkg::SampleWidthDef,
  parameter int unsigned COEF_FRAC_BITS = bq_pkg::CoefFracBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [bq_pkg::AddrWidth-1:0]          paddr,
  input  logic [bq_pkg::DataWidth-1:0]          pwdata,
  output logic [bq_pkg::DataWidth-1:0]          prdata,
  output logic                                  pready,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]        sample_out_o,
  output logic                                  clipped_o
);

  localparam int unsigned CW = bq_pkg::CoefWidth;
  localparam int unsigned DW = bq_pkg::DataWidth;

  bq_pkg::coefs_t                 coefs_q;
  bq_pkg::reg_idx_e               reg_idx;
  logic                           cfg_wr;
  logic signed [CW-1:0]           wcoef;
  logic signed [CW-1:0]           rcoef;

  logic                           s1_vld_q;
  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic signed [SAMPLE_WIDTH-1:0] x1_q, x2_q, y1_q, y2_q;
  logic                           out_vld_q;
  logic signed [SAMPLE_WIDTH-1:0] y_out_q;
  logic                           clip_q;
  logic signed [SAMPLE_WIDTH-1:0] y_d;
  logic                           clip_d;
  logic                           adv;
  logic                           in_acc;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = bq_pkg::reg_idx_e'(paddr[bq_pkg::AddrWidth-1:2]);
  assign wcoef   = pwdata[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coefs_q.b0 <= bq_pkg::CoefB0Reset;
      coefs_q.b1 <= '0;
      coefs_q.b2 <= '0;
      coefs_q.a1 <= '0;
      coefs_q.a2 <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        bq_pkg::RegCoefB0: coefs_q.b0 <= wcoef;
        bq_pkg::RegCoefB1: coefs_q.b1 <= wcoef;
        bq_pkg::RegCoefB2: coefs_q.b2 <= wcoef;
        bq_pkg::RegCoefA1: coefs_q.a1 <= wcoef;
        bq_pkg::RegCoefA2: coefs_q.a2 <= wcoef;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bq_pkg::RegCoefB0: rcoef = coefs_q.b0;
      bq_pkg::RegCoefB1: rcoef = coefs_q.b1;
      bq_pkg::RegCoefB2: rcoef = coefs_q.b2;
      bq_pkg::RegCoefA1: rcoef = coefs_q.a1;
      bq_pkg::RegCoefA2: rcoef = coefs_q.a2;
      default:           rcoef = '0;
    endcase
  end

  assign prdata = DW'(rcoef);

  // flow control
  assign adv        = s1_vld_q & (~out_vld_q | ~out_stall_i);
  assign in_stall_o = s1_vld_q & ~adv;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= 1'b1;
    end else if (adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= sample_in_i;
    end
  end

  bq_core #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_core (
    .coefs_i (coefs_q),
    .x_i     (x_q),
    .x1_i    (x1_q),
    .x2_i    (x2_q),
    .y1_i    (y1_q),
    .y2_i    (y2_q),
    .y_o     (y_d),
    .clip_o  (clip_d)
  );

  // history holds the saturated output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else if (adv) begin
      x1_q <= x_q;
      x2_q <= x1_q;
      y1_q <= y_d;
      y2_q <= y1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      y_out_q <= y_d;
      clip_q  <= clip_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign sample_out_o = y_out_q;
  assign clipped_o    = clip_q;

endmodule
